### design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that holds at every clock edge, reset included.
`define CHK_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

### design/les_pkg.sv
// Package with the types, codes and gamma table of the LED effect sequencer.
package les_pkg;

    // Number of program words; the address wrap relies on a power of two.
    localparam int PROG_DEPTH = 64;

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_SET   = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_WRITE = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        CMD_MOVE   = 3'd0,
        CMD_PAUSE  = 3'd1,
        CMD_REPEAT = 3'd2,
        CMD_STOP   = 3'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MS_IDLE  = 2'd0,
        MS_INC   = 2'd1,
        MS_DEC   = 2'd2,
        MS_PAUSE = 2'd3
    } t_motion;

    localparam logic [7:0] STOP_STEP   = 8'd10;
    localparam logic [7:0] SWITCH_STEP = 8'd255;

    // One program word as stored in the program memory.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] param_a;
        logic [7:0] param_b;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    // Gamma curve, one entry per level.
    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'h00, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h02,
        8'h02, 8'h02, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h04,
        8'h04, 8'h04, 8'h04, 8'h04, 8'h05, 8'h05, 8'h05, 8'h05,
        8'h05, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h07, 8'h07,
        8'h07, 8'h07, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
        8'h09, 8'h09, 8'h09, 8'h09, 8'h09, 8'h0a, 8'h0a, 8'h0a,
        8'h0a, 8'h0b, 8'h0b, 8'h0b, 8'h0b, 8'h0b, 8'h0c, 8'h0c,
        8'h0c, 8'h0c, 8'h0d, 8'h0d, 8'h0d, 8'h0d, 8'h0e, 8'h0e,
        8'h0e, 8'h0e, 8'h0e, 8'h0f, 8'h0f, 8'h0f, 8'h0f, 8'h10,
        8'h10, 8'h10, 8'h10, 8'h11, 8'h11, 8'h11, 8'h12, 8'h12,
        8'h12, 8'h12, 8'h13, 8'h13, 8'h13, 8'h13, 8'h14, 8'h14,
        8'h14, 8'h15, 8'h15, 8'h15, 8'h15, 8'h16, 8'h16, 8'h16,
        8'h17, 8'h17, 8'h17, 8'h18, 8'h18, 8'h18, 8'h19, 8'h19,
        8'h19, 8'h1a, 8'h1a, 8'h1a, 8'h1b, 8'h1b, 8'h1b, 8'h1c,
        8'h1c, 8'h1d, 8'h1d, 8'h1d, 8'h1e, 8'h1e, 8'h1e, 8'h1f,
        8'h1f, 8'h20, 8'h20, 8'h21, 8'h21, 8'h21, 8'h22, 8'h22,
        8'h23, 8'h23, 8'h24, 8'h24, 8'h25, 8'h25, 8'h26, 8'h26,
        8'h27, 8'h27, 8'h28, 8'h28, 8'h29, 8'h29, 8'h2a, 8'h2b,
        8'h2b, 8'h2c, 8'h2c, 8'h2d, 8'h2e, 8'h2e, 8'h2f, 8'h2f,
        8'h30, 8'h31, 8'h31, 8'h32, 8'h33, 8'h34, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3b,
        8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43,
        8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h4b,
        8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h53, 8'h54, 8'h55,
        8'h57, 8'h58, 8'h59, 8'h5b, 8'h5c, 8'h5e, 8'h5f, 8'h61,
        8'h62, 8'h64, 8'h66, 8'h67, 8'h69, 8'h6b, 8'h6d, 8'h6e,
        8'h70, 8'h72, 8'h74, 8'h76, 8'h78, 8'h7a, 8'h7c, 8'h7e,
        8'h80, 8'h83, 8'h85, 8'h87, 8'h8a, 8'h8c, 8'h8e, 8'h91,
        8'h93, 8'h96, 8'h99, 8'h9b, 8'h9e, 8'ha1, 8'ha4, 8'ha7,
        8'haa, 8'had, 8'hb0, 8'hb3, 8'hb7, 8'hba, 8'hbd, 8'hc1,
        8'hc4, 8'hc8, 8'hcc, 8'hd0, 8'hd3, 8'hd7, 8'hdb, 8'hdf,
        8'he4, 8'he8, 8'hec, 8'hf1, 8'hf5, 8'hfa, 8'hff, 8'hff
    };

endpackage

### design/les_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module les_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/led_effect_sequencer.sv
// Top level of the LED effect sequencer.
// LED effect sequencer: one result word for every input word, one word per clock
// while results are taken. An accepted request is registered together with the
// program word the memory reads at the program counter; stage two then applies
// the ramp, pause and program step in one pass and registers the result when the
// result register is free. A new word is taken every cycle as long as the result
// register is free or being emptied. A program word written right before a tick
// that executes it is forwarded from the write path.
module led_effect_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_level,
    input  logic [7:0] i_step,
    input  logic [5:0] i_address,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_param_a,
    input  logic [7:0] i_param_b,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pwm_duty,
    output logic       o_switch_pin,
    output logic       o_busy_res
);

    localparam int AW = $clog2(les_pkg::PROG_DEPTH);

    logic              r_pwm_mode;
    logic [7:0]        r_cur, r_tgt, r_step, r_idle, r_pause, r_rep;
    les_pkg::t_motion  r_ms;
    logic [AW-1:0]     r_pc;
    logic              r_run;

    logic              r_s1_valid;
    logic [2:0]        r_s1_req;
    logic [7:0]        r_s1_level, r_s1_step;
    logic [AW-1:0]     r_s1_addr;
    logic              r_fwd;
    les_pkg::t_word    r_fwd_word;

    logic              r_out_valid;
    logic [7:0]        r_duty;
    logic              r_pin, r_busy;

    logic              acc_in, s1_go, s2_free;
    logic [AW-1:0]     in_addr, rd_addr;
    les_pkg::t_word    wr_word, rd_word, word;

    logic [7:0]        n_cur, n_tgt, n_step, n_idle, n_pause, n_rep;
    les_pkg::t_motion  n_ms;
    logic [AW-1:0]     n_pc;
    logic              n_run;
    logic [8:0]        sum;
    logic [7:0]        lv;

    // Two-stage handshake: stage one holds a request, stage two the result.
    assign s2_free = !r_out_valid || i_ready;
    assign s1_go   = r_s1_valid && s2_free;
    assign o_ready = !r_s1_valid || s2_free;
    assign acc_in  = i_valid && o_ready;
    assign in_addr = AW'(i_address);

    assign wr_word = '{cmd: i_cmd, param_a: i_param_a, param_b: i_param_b};

    // The word to fetch follows the program counter that stage two leaves.
    assign rd_addr = s1_go ? n_pc : r_pc;

    les_ram #(.WIDTH(les_pkg::WORD_W), .DEPTH(les_pkg::PROG_DEPTH)) u_prog (
        .i_clk  (i_clk),
        .i_we   (acc_in && i_req_type == les_pkg::REQ_WRITE),
        .i_waddr(in_addr),
        .i_wdata(wr_word),
        .i_raddr(rd_addr),
        .o_rdata(rd_word)
    );

    assign word = r_fwd ? r_fwd_word : rd_word;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_pwm_mode <= i_cfg_wdata;
        end
    end

    // Stage one: request register plus write forwarding toward the fetch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (acc_in) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (acc_in && i_req_type == les_pkg::REQ_WRITE && in_addr == rd_addr) begin
                r_fwd <= 1'b1;
            end else if (s1_go || acc_in) begin
                r_fwd <= 1'b0;
            end
        end
        if (acc_in && i_req_type == les_pkg::REQ_WRITE && in_addr == rd_addr) begin
            r_fwd_word <= wr_word;
        end
        if (acc_in) begin
            r_s1_req   <= i_req_type;
            r_s1_level <= i_level;
            r_s1_step  <= i_step;
            r_s1_addr  <= in_addr;
        end
    end

    // Stage two: motion, program step and requests in one pass.
    always_comb begin
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_step  = r_step;
        n_idle  = r_idle;
        n_ms    = r_ms;
        n_pause = r_pause;
        n_pc    = r_pc;
        n_run   = r_run;
        n_rep   = r_rep;
        sum     = 9'd0;
        lv      = r_cur;
        if (r_s1_valid) begin
            case (r_s1_req)
                les_pkg::REQ_TICK: begin
                    case (r_ms)
                        les_pkg::MS_INC: begin
                            sum = {1'b0, r_cur} + {1'b0, r_step};
                            lv  = (sum > {1'b0, r_tgt}) ? r_tgt : sum[7:0];
                        end
                        les_pkg::MS_DEC: begin
                            lv = (r_cur > r_step) ? r_cur - r_step : 8'd0;
                            lv = (lv < r_tgt) ? r_tgt : lv;
                        end
                        default: begin
                            lv = r_cur;
                        end
                    endcase
                    n_cur = lv;
                    if ((r_ms == les_pkg::MS_INC || r_ms == les_pkg::MS_DEC) && lv == r_tgt) begin
                        n_ms = les_pkg::MS_IDLE;
                    end
                    if (r_ms == les_pkg::MS_PAUSE) begin
                        n_pause = r_pause - 8'd1;
                        if (n_pause == 8'd0) begin
                            n_ms = les_pkg::MS_IDLE;
                        end
                    end
                    // One program word runs when the engine has gone idle and a program runs.
                    if (n_ms == les_pkg::MS_IDLE && r_run) begin
                        n_pc = r_pc + AW'(1);
                        case (word.cmd)
                            les_pkg::CMD_MOVE: begin
                                n_tgt  = word.param_a;
                                n_step = r_pwm_mode ? word.param_b : les_pkg::SWITCH_STEP;
                                n_ms   = (n_cur < word.param_a) ? les_pkg::MS_INC
                                                                : les_pkg::MS_DEC;
                            end
                            les_pkg::CMD_PAUSE: begin
                                n_pause = word.param_a;
                                n_ms    = les_pkg::MS_PAUSE;
                            end
                            les_pkg::CMD_REPEAT: begin
                                n_rep = r_rep + 8'd1;
                                if (n_rep < word.param_b) begin
                                    n_pc = r_pc - word.param_a[AW-1:0];
                                end
                            end
                            les_pkg::CMD_STOP: begin
                                n_run  = 1'b0;
                                n_tgt  = r_idle;
                                n_step = r_pwm_mode ? les_pkg::STOP_STEP : les_pkg::SWITCH_STEP;
                                n_ms   = (n_cur < r_idle) ? les_pkg::MS_INC : les_pkg::MS_DEC;
                            end
                            default: begin
                                n_pc = r_pc + AW'(1);
                            end
                        endcase
                    end
                end
                les_pkg::REQ_START: begin
                    n_run = 1'b1;
                    n_pc  = r_s1_addr;
                    n_ms  = les_pkg::MS_IDLE;
                    n_rep = 8'd0;
                end
                les_pkg::REQ_SET: begin
                    n_run  = 1'b0;
                    n_idle = r_s1_level;
                    n_tgt  = r_s1_level;
                    n_step = r_pwm_mode ? r_s1_step : les_pkg::SWITCH_STEP;
                    n_ms   = (r_cur < r_s1_level) ? les_pkg::MS_INC : les_pkg::MS_DEC;
                end
                les_pkg::REQ_STOP: begin
                    n_run  = 1'b0;
                    n_tgt  = r_idle;
                    n_step = r_pwm_mode ? les_pkg::STOP_STEP : les_pkg::SWITCH_STEP;
                    n_ms   = (r_cur < r_idle) ? les_pkg::MS_INC : les_pkg::MS_DEC;
                end
                default: begin
                    n_run = r_run;
                end
            endcase
        end
    end

    // Engine state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_tgt       <= '0;
            r_step      <= '0;
            r_idle      <= '0;
            r_ms        <= les_pkg::MS_IDLE;
            r_pause     <= '0;
            r_pc        <= '0;
            r_run       <= 1'b0;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_cur       <= n_cur;
                r_tgt       <= n_tgt;
                r_step      <= n_step;
                r_idle      <= n_idle;
                r_ms        <= n_ms;
                r_pause     <= n_pause;
                r_pc        <= n_pc;
                r_run       <= n_run;
                r_rep       <= n_rep;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s1_go) begin
            r_duty <= r_pwm_mode ? les_pkg::GAMMA_ROM[n_cur] : 8'd0;
            r_pin  <= !r_pwm_mode && n_cur == 8'd0;
            r_busy <= n_ms != les_pkg::MS_IDLE || n_run;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pwm_duty   = r_duty;
    assign o_switch_pin = r_pin;
    assign o_busy_res   = r_busy;

endmodule

### design/les_checker.sv
// Port-level checker for the LED effect sequencer, bound to the top level.
`include "assert_macros.svh"
module les_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_pwm_duty,
    input logic       o_switch_pin
);

    // A result stays until it is taken.
    `CHK_IMPLY(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result dropped")
    // While a result is valid, duty and pin are never active together.
    `CHK_IMPLY(a_excl, i_clk, i_rst_n, o_valid |-> !(o_switch_pin && o_pwm_duty != 8'd0),
        "duty and pin both active")
    // No result appears right after reset.
    `CHK_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "result after reset")
    // A taken input gives a result after stage one when the output is free.
    `CHK_IMPLY(a_lat, i_clk, i_rst_n, i_valid && o_ready && !o_valid |=> ##1 o_valid,
        "result missing")

endmodule

bind led_effect_sequencer les_checker u_les_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_pwm_duty  (o_pwm_duty),
    .o_switch_pin(o_switch_pin)
);

### sim/tb_top.sv
// Self-checking testbench for the LED effect sequencer.
`timescale 1ns / 1ps

module tb_top;

    // One request word as offered to the block.
    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] level;
        logic [7:0] step;
        logic [5:0] address;
        logic [2:0] cmd;
        logic [7:0] param_a;
        logic [7:0] param_b;
    } t_request;

    // One expected result word.
    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       switch_pin;
        logic       busy_res;
    } t_led_out;

    localparam int DEPTH = les_pkg::PROG_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_req_type = '0;
    logic [7:0] i_level = '0;
    logic [7:0] i_step = '0;
    logic [5:0] i_address = '0;
    logic [2:0] i_cmd = '0;
    logic [7:0] i_param_a = '0;
    logic [7:0] i_param_b = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_pwm_duty;
    logic       o_switch_pin;
    logic       o_busy_res;

    led_effect_sequencer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_level(i_level), .i_step(i_step),
        .i_address(i_address), .i_cmd(i_cmd), .i_param_a(i_param_a),
        .i_param_b(i_param_b),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pwm_duty(o_pwm_duty), .o_switch_pin(o_switch_pin),
        .o_busy_res(o_busy_res)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the sequencer state.
    logic    mdl_pwm_mode;
    logic [7:0] mdl_level, mdl_target, mdl_step, mdl_idle, mdl_pause, mdl_repeat;
    les_pkg::t_motion mdl_motion;
    logic [5:0] mdl_pc;
    logic    mdl_running;
    les_pkg::t_word mdl_prog [DEPTH];
    bit      mdl_written [DEPTH];

    t_request pending_words[$];
    t_led_out expected_outs[$];
    int sent_count, recv_count, mismatch_count, cycle_count;
    int send_idle_pct, recv_stall_pct, hold_off_cycles;
    int pwm_results, switch_results;

    task automatic reset_shadow();
        mdl_pwm_mode = 1'b1;
        mdl_level = '0; mdl_target = '0; mdl_step = '0; mdl_idle = '0;
        mdl_pause = '0; mdl_repeat = '0; mdl_motion = les_pkg::MS_IDLE;
        mdl_pc = '0; mdl_running = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            mdl_prog[i] = '0;
            mdl_written[i] = 1'b0;
        end
    endtask

    function automatic void begin_ramp(input logic [7:0] tgt, input logic [7:0] stp);
        mdl_target = tgt;
        mdl_step = mdl_pwm_mode ? stp : les_pkg::SWITCH_STEP;
        mdl_motion = (mdl_level < tgt) ? les_pkg::MS_INC : les_pkg::MS_DEC;
    endfunction

    function automatic void advance_ramp();
        int lv;
        case (mdl_motion)
            les_pkg::MS_INC: begin
                lv = int'(mdl_level) + int'(mdl_step);
                if (lv > mdl_target) lv = mdl_target;
                if (lv == mdl_target) mdl_motion = les_pkg::MS_IDLE;
                mdl_level = lv[7:0];
            end
            les_pkg::MS_DEC: begin
                lv = (mdl_level > mdl_step) ? int'(mdl_level) - int'(mdl_step) : 0;
                if (lv < mdl_target) lv = mdl_target;
                if (lv == mdl_target) mdl_motion = les_pkg::MS_IDLE;
                mdl_level = lv[7:0];
            end
            les_pkg::MS_PAUSE: begin
                mdl_pause = mdl_pause - 8'd1;
                if (mdl_pause == 8'd0) mdl_motion = les_pkg::MS_IDLE;
            end
            default: ;
        endcase
    endfunction

    function automatic void run_program_word();
        les_pkg::t_word w;
        logic [5:0] here;
        here = mdl_pc;
        w = mdl_prog[here];
        mdl_pc = here + 6'd1;
        case (w.cmd)
            les_pkg::CMD_MOVE: begin_ramp(w.param_a, w.param_b);
            les_pkg::CMD_PAUSE: begin
                mdl_pause = w.param_a;
                mdl_motion = les_pkg::MS_PAUSE;
            end
            les_pkg::CMD_REPEAT: begin
                mdl_repeat = mdl_repeat + 8'd1;
                if (mdl_repeat < w.param_b) mdl_pc = here - w.param_a[5:0];
            end
            les_pkg::CMD_STOP: begin
                mdl_running = 1'b0;
                begin_ramp(mdl_idle, les_pkg::STOP_STEP);
            end
            default: ;
        endcase
    endfunction

    // Applies one request to the shadow state and returns the expected output.
    function automatic t_led_out apply_request(input t_request r);
        t_led_out o;
        case (r.req_type)
            les_pkg::REQ_TICK: begin
                advance_ramp();
                if (mdl_motion == les_pkg::MS_IDLE && mdl_running) run_program_word();
            end
            les_pkg::REQ_START: begin
                mdl_running = 1'b1;
                mdl_pc = r.address;
                mdl_motion = les_pkg::MS_IDLE;
                mdl_repeat = '0;
            end
            les_pkg::REQ_SET: begin
                mdl_running = 1'b0;
                mdl_idle = r.level;
                begin_ramp(r.level, r.step);
            end
            les_pkg::REQ_STOP: begin
                mdl_running = 1'b0;
                begin_ramp(mdl_idle, les_pkg::STOP_STEP);
            end
            les_pkg::REQ_WRITE: begin
                mdl_prog[r.address] = '{cmd: r.cmd, param_a: r.param_a, param_b: r.param_b};
            end
            default: ;
        endcase
        o.pwm_duty = mdl_pwm_mode ? les_pkg::GAMMA_ROM[mdl_level] : 8'd0;
        o.switch_pin = (!mdl_pwm_mode && mdl_level == 8'd0);
        o.busy_res = (mdl_motion != les_pkg::MS_IDLE) || mdl_running;
        return o;
    endfunction

    function automatic t_request make_word(input logic [2:0] kind);
        t_request r;
        r = '{req_type: kind, level: 8'($urandom), step: 8'($urandom),
              address: 6'($urandom), cmd: 3'($urandom), param_a: 8'($urandom),
              param_b: 8'($urandom)};
        return r;
    endfunction

    // Queues one request, tracking which program addresses hold a word.
    task automatic queue_word(input t_request r);
        if (r.req_type == les_pkg::REQ_WRITE) mdl_written[r.address] = 1'b1;
        pending_words.push_back(r);
    endtask

    // Queues a program write with given contents.
    task automatic queue_prog(input logic [5:0] a, input les_pkg::t_cmd c,
                              input logic [7:0] pa, input logic [7:0] pb);
        t_request r;
        r = make_word(les_pkg::REQ_WRITE);
        r.address = a; r.cmd = c; r.param_a = pa; r.param_b = pb;
        queue_word(r);
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++) queue_word(make_word(les_pkg::REQ_TICK));
    endtask

    // Writes a short program at a random base: moves, short pauses, repeats, unknown codes.
    task automatic queue_program(output logic [5:0] base, output int len);
        int c;
        base = 6'($urandom);
        len = $urandom_range(2, 6);
        for (int i = 0; i < len; i++) begin
            c = $urandom_range(0, 9);
            if (i == len - 1)
                queue_prog(base + i[5:0],
                           ($urandom_range(0, 3) == 0) ? les_pkg::CMD_REPEAT
                                                       : les_pkg::CMD_STOP,
                           8'($urandom_range(1, len - 1)), 8'($urandom_range(0, 4)));
            else if (c < 5)
                queue_prog(base + i[5:0], les_pkg::CMD_MOVE, 8'($urandom),
                           8'($urandom_range(20, 255)));
            else if (c < 7)
                queue_prog(base + i[5:0], les_pkg::CMD_PAUSE, 8'($urandom_range(1, 6)),
                           8'($urandom));
            else if (c < 8)
                queue_prog(base + i[5:0], les_pkg::t_cmd'(3'($urandom_range(4, 7))),
                           8'($urandom), 8'($urandom));
            else
                // A jump never reaches back past the first word of the block.
                queue_prog(base + i[5:0], les_pkg::CMD_REPEAT, 8'($urandom_range(0, i)),
                           8'($urandom_range(0, 3)));
        end
        // Keep a stop after the block so a jump-free run never leaves written space.
        queue_prog(base + len[5:0], les_pkg::CMD_STOP, 8'd0, 8'd0);
    endtask

    // True when the program start address holds a written word.
    function automatic bit start_is_safe(input logic [5:0] a);
        return mdl_written[a];
    endfunction

    // Random noise items that never reach an unwritten program word.
    task automatic queue_noise();
        t_request r;
        r = make_word(3'($urandom_range(0, 7)));
        if (r.req_type == les_pkg::REQ_START) r.req_type = les_pkg::REQ_STOP;
        if (r.req_type == les_pkg::REQ_WRITE) begin
            // Overwriting a live program could lead into unwritten words; keep them stops.
            r.cmd = les_pkg::CMD_STOP;
        end
        queue_word(r);
    endtask

    // Waits until all queued words are sent and checked, plus the block's latency.
    task automatic drain();
        while (pending_words.size() != 0 || expected_outs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_pwm_mode = m;
    endtask

    // Sender: offers the oldest queued word and predicts it on acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_outs.push_back(apply_request(pending_words.pop_front()));
                sent_count++;
            end
            if (!(i_valid && !o_ready)) begin
                if (pending_words.size() != 0 && !(i_valid && o_ready && pending_words.size() == 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    {i_req_type, i_level, i_step, i_address, i_cmd, i_param_a, i_param_b}
                        <= pending_words[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_led_out exp_out;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                recv_count++;
                if (expected_outs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result word");
                end else begin
                    exp_out = expected_outs.pop_front();
                    if (exp_out.switch_pin) switch_results++;
                    else pwm_results++;
                    if (exp_out != {o_pwm_duty, o_switch_pin, o_busy_res}) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: duty %h/%h pin %b/%b busy %b/%b",
                                     exp_out.pwm_duty, o_pwm_duty, exp_out.switch_pin,
                                     o_switch_pin, exp_out.busy_res, o_busy_res);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Run timeout.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus and phases.
    initial begin
        logic [5:0] base;
        int len;
        int phase_items;
        int n_ticks;
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: extremes, every request and command.
        begin
            t_request r;
            r = make_word(les_pkg::REQ_SET); r.level = 8'd255; r.step = 8'd255; queue_word(r);
            queue_ticks(2);
            r = make_word(les_pkg::REQ_SET); r.level = 8'd0; r.step = 8'd1; queue_word(r);
            queue_ticks(2);
            r = make_word(les_pkg::REQ_SET); r.level = 8'd0; r.step = 8'd0; queue_word(r);
            queue_ticks(1);
            r = make_word(les_pkg::REQ_STOP); queue_word(r);
            queue_ticks(1);
            queue_prog(6'd63, les_pkg::CMD_PAUSE, 8'd0, 8'd255);
            queue_prog(6'd0, les_pkg::CMD_MOVE, 8'd200, 8'd255);
            queue_prog(6'd1, les_pkg::CMD_REPEAT, 8'd1, 8'd2);
            queue_prog(6'd2, les_pkg::t_cmd'(3'd7), 8'd255, 8'd0);
            queue_prog(6'd3, les_pkg::CMD_STOP, 8'd0, 8'd0);
            r = make_word(les_pkg::REQ_START); r.address = 6'd0; queue_word(r);
            queue_ticks(4);
            r = make_word(3'd7); queue_word(r);
            queue_ticks(2);
        end
        drain();

        // Random phases over modes and idling profiles.
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 16 : 83) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 16 : 83) : 0;
            if (ph % 4 == 1 && ph < 4) send_idle_pct = 83;
            write_mode((ph % 3) != 1);
            if (ph == 2) hold_off_cycles = 300;
            phase_items = 0;
            while (phase_items < 225) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_program(base, len);
                    queue_word('{req_type: les_pkg::REQ_START, level: 8'($urandom),
                                 step: 8'($urandom), address: base, cmd: 3'($urandom),
                                 param_a: 8'($urandom), param_b: 8'($urandom)});
                    n_ticks = $urandom_range(4, 20);
                    queue_ticks(n_ticks);
                    phase_items += len + 2 + n_ticks;
                end else begin
                    queue_noise();
                    n_ticks = $urandom_range(1, 4);
                    queue_ticks(n_ticks);
                    phase_items += 1 + n_ticks;
                end
                if (start_is_safe(base) && $urandom_range(0, 20) == 0) drain();
            end
            drain();
        end

        $display("Sent %0d words and checked %0d results over 8 phases of modes and stalls.",
                 sent_count, recv_count);
        $display("Results with the switch pin high: %0d, others: %0d.",
                 switch_results, pwm_results);
        if (mismatch_count == 0 && expected_outs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        sent_count = 0; recv_count = 0; mismatch_count = 0; cycle_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        pwm_results = 0; switch_results = 0;
    end

endmodule

### files.f
+incdir+design
design/les_pkg.sv
design/les_ram.sv
design/led_effect_sequencer.sv
design/les_checker.sv
sim/tb_top.sv
